// File: rtl/crp_pkg.sv
`timescale 1ns / 1ps

package crp_pkg;

   localparam int MAX_POINTS_DEF = 64;

   localparam int COORD_W = 32;
   localparam int S_W     = 48;             // segment position, unsigned Q32.16
   localparam int OVER_W  = 49;             // signed overshoot in Q32.16 plus a sign bit
   localparam int U_W     = 17;             // fraction, 65536 is one
   localparam int WT_W    = 22;             // basis weights at twice their value
   localparam int QM_W    = 34;             // control point after mirroring
   localparam int PROD_W  = WT_W + QM_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int TAN_W   = SUM_W - 17;     // position and tangent after the shift
   localparam int EXT_W   = 42;             // clamped product, within +-2^40

   localparam logic [U_W-1:0] ONE_Q16   = 17'h10000;
   localparam logic [63:0]    EXT_LIMIT = 64'h0000_0100_0000_0000;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CSR_POINT_COUNT  = 2'd0,
      CSR_START_TIME   = 2'd1,
      CSR_INV_INTERVAL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                      mode;
      logic [5:0]                point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic signed [COORD_W-1:0] query_time;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] vel_x;
      logic signed [COORD_W-1:0] vel_y;
      logic signed [COORD_W-1:0] vel_z;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0][WT_W-1:0] wp;
      logic [3:0][WT_W-1:0] wd;
   } basis_type;

   typedef struct packed {
      logic has_prev;
      logic has_next;
   } nbr_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [COORD_W-1:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/crp_ram.sv
`timescale 1ns / 1ps

module crp_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/crp_basis.sv
`timescale 1ns / 1ps

module crp_basis (
   input  logic                          clock,
   input  logic [crp_pkg::U_W-1:0]       u,
   output crp_pkg::basis_type            basis
);

   localparam int UW = crp_pkg::U_W;
   localparam int WW = crp_pkg::WT_W;

   logic [UW-1:0] u2_ff, u2_in, u_d1_ff;
   logic [UW-1:0] u3_ff, u3_in, u2_d_ff, u_d2_ff;
   logic [2*UW-1:0] sq, cb;
   crp_pkg::basis_type basis_ff, basis_in;
   logic signed [WW-1:0] a1, a2, a3, one;

   always_comb begin
      sq    = (2*UW)'(u) * (2*UW)'(u);
      u2_in = sq[16 +: UW];
      cb    = (2*UW)'(u2_ff) * (2*UW)'(u_d1_ff);
      u3_in = cb[16 +: UW];
   end

   always_comb begin
      a1  = $signed(WW'(u_d2_ff));
      a2  = $signed(WW'(u2_d_ff));
      a3  = $signed(WW'(u3_ff));
      one = $signed(WW'(crp_pkg::ONE_Q16));
      basis_in.wp[0] = -a3 + WW'(2) * a2 - a1;
      basis_in.wp[1] = WW'(3) * a3 - WW'(5) * a2 + WW'(2) * one;
      basis_in.wp[2] = -(WW'(3) * a3) + WW'(4) * a2 + a1;
      basis_in.wp[3] = a3 - a2;
      basis_in.wd[0] = -(WW'(3) * a2) + WW'(4) * a1 - one;
      basis_in.wd[1] = WW'(9) * a2 - WW'(10) * a1;
      basis_in.wd[2] = -(WW'(9) * a2) + WW'(8) * a1 + one;
      basis_in.wd[3] = WW'(3) * a2 - WW'(2) * a1;
   end

   always_ff @(posedge clock) begin
      u2_ff    <= u2_in;
      u_d1_ff  <= u;
      u3_ff    <= u3_in;
      u2_d_ff  <= u2_ff;
      u_d2_ff  <= u_d1_ff;
      basis_ff <= basis_in;
   end

   assign basis = basis_ff;

endmodule

// File: rtl/crp_mulq16.sv
`timescale 1ns / 1ps

module crp_mulq16 (
   input  logic                              clock,
   input  logic signed [63:0]                a,
   input  logic signed [63:0]                b,
   output logic signed [crp_pkg::EXT_W-1:0]  res
);

   localparam int EW = crp_pkg::EXT_W;

   logic [63:0] am_ff, bm_ff;
   logic        neg_a_ff, neg_b_ff, neg_c_ff;
   logic [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic [63:0] lo_ff, hi_ff, lo_in, hi_in;
   logic [33:0] mid;
   logic [63:0] r, mag;
   logic        big;
   logic signed [EW-1:0] res_ff, res_in;

   always_comb begin
      mid   = 34'(p0_ff[63:32]) + 34'(p1_ff[31:0]) + 34'(p2_ff[31:0]);
      lo_in = {mid[31:0], p0_ff[31:0]};
      hi_in = p3_ff + 64'(p1_ff[63:32]) + 64'(p2_ff[63:32]) + 64'(mid[33:32]);
   end

   // Saturate to the limit, otherwise floor the signed result.
   always_comb begin
      r   = {hi_ff[15:0], lo_ff[63:16]};
      big = (hi_ff[63:16] != '0) || (r >= crp_pkg::EXT_LIMIT);
      mag = big ? crp_pkg::EXT_LIMIT : r;
      if (!neg_c_ff) begin
         res_in = EW'(mag);
      end else if (big) begin
         res_in = EW'(64'd0 - mag);
      end else begin
         res_in = EW'(64'd0 - (r + 64'(lo_ff[15:0] != '0)));
      end
   end

   always_ff @(posedge clock) begin
      am_ff    <= a[63] ? 64'(-a) : 64'(a);
      bm_ff    <= b[63] ? 64'(-b) : 64'(b);
      neg_a_ff <= a[63] ^ b[63];
      p0_ff    <= 64'(am_ff[31:0])  * 64'(bm_ff[31:0]);
      p1_ff    <= 64'(am_ff[31:0])  * 64'(bm_ff[63:32]);
      p2_ff    <= 64'(am_ff[63:32]) * 64'(bm_ff[31:0]);
      p3_ff    <= 64'(am_ff[63:32]) * 64'(bm_ff[63:32]);
      neg_b_ff <= neg_a_ff;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      neg_c_ff <= neg_b_ff;
      res_ff   <= res_in;
   end

   assign res = res_ff;

endmodule

// File: rtl/crp_lane.sv
`timescale 1ns / 1ps

module crp_lane (
   input  logic                                   clock,
   input  logic signed [crp_pkg::COORD_W-1:0]     q_raw [4],
   input  crp_pkg::nbr_type                       nbr,
   input  crp_pkg::basis_type                     basis,
   input  logic signed [crp_pkg::OVER_W-1:0]      over,
   input  logic                                   over_nz,
   input  logic [31:0]                            inv_interval,
   output logic signed [crp_pkg::COORD_W-1:0]     pos,
   output logic signed [crp_pkg::COORD_W-1:0]     vel
);

   localparam int QW = crp_pkg::QM_W;
   localparam int PW = crp_pkg::PROD_W;
   localparam int SW = crp_pkg::SUM_W;
   localparam int TW = crp_pkg::TAN_W;

   logic signed [crp_pkg::COORD_W-1:0] raw_ff [4];
   crp_pkg::nbr_type                   nbr_ff;
   logic signed [QW-1:0] qm_ff [4], qm_in [4], ext [4];
   logic signed [PW-1:0] pp_ff [4], pd_ff [4];
   logic signed [SW-1:0] psum, dsum;
   logic signed [TW-1:0] pos_ff, tan_ff, pos_d_ff [4];
   logic signed [crp_pkg::EXT_W-1:0] ext_res, vel_res;
   logic signed [63:0] pos_sum;

   // Missing end neighbours are mirrored about the segment ends.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         ext[j] = QW'(raw_ff[j]);
      end
      qm_in[1] = ext[1];
      qm_in[2] = ext[2];
      qm_in[0] = nbr_ff.has_prev ? ext[0] : (ext[1] <<< 1) - ext[2];
      qm_in[3] = nbr_ff.has_next ? ext[3] : (ext[2] <<< 1) - ext[1];
   end

   always_comb begin
      psum = '0;
      dsum = '0;
      for (int j = 0; j < 4; j++) begin
         psum = psum + SW'(pp_ff[j]);
         dsum = dsum + SW'(pd_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= q_raw;
      nbr_ff <= nbr;
      qm_ff  <= qm_in;
      for (int j = 0; j < 4; j++) begin
         pp_ff[j] <= $signed(basis.wp[j]) * qm_ff[j];
         pd_ff[j] <= $signed(basis.wd[j]) * qm_ff[j];
      end
      pos_ff <= psum[SW-1:17];
      tan_ff <= dsum[SW-1:17];
      pos_d_ff[0] <= pos_ff;
      for (int j = 1; j < 4; j++) begin
         pos_d_ff[j] <= pos_d_ff[j-1];
      end
   end

   crp_mulq16 u_ext (
      .clock (clock),
      .a     (64'(tan_ff)),
      .b     (64'(over)),
      .res   (ext_res)
   );

   crp_mulq16 u_vel (
      .clock (clock),
      .a     (64'(tan_ff)),
      .b     ($signed({32'd0, inv_interval})),
      .res   (vel_res)
   );

   always_comb begin
      pos_sum = 64'(pos_d_ff[3]);
      if (over_nz) begin
         pos_sum = pos_sum + 64'(ext_res);
      end
      pos = crp_pkg::sat32(pos_sum);
      vel = crp_pkg::sat32(64'(vel_res));
   end

endmodule

// File: rtl/catmull_rom_path_eval.sv
`timescale 1ns / 1ps

// Throughput: one word per cycle outside reset (busy follows reset), loads and
// queries mixed freely; the receiver cannot stall.
// The rate is set by the four point banks, each read once per query through one port.
// Reset clears the pipeline and the registers (two points, start 0, interval one second);
// the point table keeps no reset value and must be loaded before it is queried.
module catmull_rom_path_eval #(
   parameter int MAX_POINTS = crp_pkg::MAX_POINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  crp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output crp_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   // The table is split over four banks by the low two index bits, so the four
   // neighbours of any segment always sit in four different banks.
   localparam int BANK_DEPTH = (MAX_POINTS + 3) / 4;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int SEG_W      = (MAX_POINTS > 2) ? $clog2(MAX_POINTS - 1) : 1;
   localparam int IDX_W      = $clog2(MAX_POINTS + 1) + 1;
   localparam int CNT_W      = ($clog2(MAX_POINTS + 1) > 7) ? $clog2(MAX_POINTS + 1) : 7;
   localparam int PT_W       = 3 * crp_pkg::COORD_W;
   localparam int S_W        = crp_pkg::S_W;
   localparam int OVER_W     = crp_pkg::OVER_W;

   // Configuration registers.
   logic [6:0]  point_count_ff;
   logic [31:0] start_time_ff;
   logic [31:0] inv_interval_ff;

   // Front pipeline: time difference, magnitude, scaled position, segment and fraction.
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic              s1_mode_ff, s2_mode_ff, s3_mode_ff, s4_mode_ff;
   logic [5:0]        s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [PT_W-1:0]   s1_pt_ff, s2_pt_ff, s3_pt_ff, s4_pt_ff;
   logic signed [32:0] s1_diff_ff, s1_diff_in;
   logic [31:0]       s2_dm_ff;
   logic              s2_neg_ff, s3_neg_ff;
   logic [63:0]       prod;
   logic [S_W-1:0]    s3_s_ff;
   logic [SEG_W-1:0]  s4_seg_ff, s4_seg_in;
   logic [crp_pkg::U_W-1:0] s4_u_ff, s4_u_in;
   logic signed [OVER_W-1:0] s4_over_ff, s4_over_in;

   logic [CNT_W-1:0]    n_eff;
   logic [CNT_W+15:0]   span;
   logic                accept;

   // Bank access.
   logic [IDX_W-1:0]   base;
   logic [BANK_AW-1:0] rd_addr [4];
   logic [BANK_AW-1:0] wr_addr;
   logic [3:0]         bank_we;
   logic [PT_W-1:0]    bank_rd [4];
   logic               load_ok;

   logic [1:0]              rot_ff;
   crp_pkg::nbr_type        nbr_ff, nbr_in;
   logic signed [OVER_W-1:0] over_d_ff [5];
   logic [8:0]              ovnz_ff;
   logic [8:0]              qv_ff;

   crp_pkg::basis_type      basis;
   logic signed [crp_pkg::COORD_W-1:0] q_raw [3][4];
   logic signed [crp_pkg::COORD_W-1:0] pos [3], vel [3];

   logic                  rsp_valid_ff;
   crp_pkg::rsp_word_type rsp_word_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------
   // Configuration port: plain writes, ignored beyond the register list.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff  <= 7'd2;
         start_time_ff   <= '0;
         inv_interval_ff <= 32'h0001_0000;
      end else if (csr_write_en) begin
         unique case (crp_pkg::csr_index_type'(csr_index))
            crp_pkg::CSR_POINT_COUNT:  point_count_ff  <= csr_wdata[6:0];
            crp_pkg::CSR_START_TIME:   start_time_ff   <= csr_wdata;
            crp_pkg::CSR_INV_INTERVAL: inv_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Points in use, held within two and the table depth.
   always_comb begin
      if (point_count_ff < 7'd2) begin
         n_eff = CNT_W'(2);
      end else if (32'(point_count_ff) > MAX_POINTS) begin
         n_eff = CNT_W'(MAX_POINTS);
      end else begin
         n_eff = CNT_W'(point_count_ff);
      end
      span = {n_eff - CNT_W'(1), 16'h0000};
   end

   // ---------------------------------------------------------------------
   // Front pipeline. Load words ride along so that their table write lands
   // in the same stage as a query's read, which keeps words in order.
   // ---------------------------------------------------------------------
   always_comb begin
      s1_diff_in = $signed({req_word.query_time[31], req_word.query_time})
                 - $signed({start_time_ff[31], start_time_ff});
      prod       = 64'(s2_dm_ff) * 64'(inv_interval_ff);
   end

   // Split the position into segment and fraction, or clamp it to an end of
   // the path and keep the overshoot for the linear extension.
   always_comb begin
      if (s3_neg_ff || (s3_s_ff == '0)) begin
         s4_seg_in  = '0;
         s4_u_in    = '0;
         s4_over_in = -$signed({1'b0, s3_s_ff});
      end else if (s3_s_ff >= S_W'(span)) begin
         s4_seg_in  = SEG_W'(n_eff - CNT_W'(2));
         s4_u_in    = crp_pkg::ONE_Q16;
         s4_over_in = $signed({1'b0, s3_s_ff - S_W'(span)});
      end else begin
         s4_seg_in  = s3_s_ff[16 +: SEG_W];
         s4_u_in    = {1'b0, s3_s_ff[15:0]};
         s4_over_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff <= req_word.mode;
      s1_idx_ff  <= req_word.point_index;
      s1_pt_ff   <= {req_word.coord_z, req_word.coord_y, req_word.coord_x};
      s1_diff_ff <= s1_diff_in;
      s2_mode_ff <= s1_mode_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_pt_ff   <= s1_pt_ff;
      s2_neg_ff  <= s1_diff_ff[32];
      s2_dm_ff   <= s1_diff_ff[32] ? 32'(-s1_diff_ff) : s1_diff_ff[31:0];
      s3_mode_ff <= s2_mode_ff;
      s3_idx_ff  <= s2_idx_ff;
      s3_pt_ff   <= s2_pt_ff;
      s3_neg_ff  <= s2_neg_ff;
      s3_s_ff    <= prod[16 +: S_W];
      s4_mode_ff <= s3_mode_ff;
      s4_idx_ff  <= s3_idx_ff;
      s4_pt_ff   <= s3_pt_ff;
      s4_seg_ff  <= s4_seg_in;
      s4_u_ff    <= s4_u_in;
      s4_over_ff <= s4_over_in;
   end

   // ---------------------------------------------------------------------
   // Point banks. Neighbour j of the segment is point seg-1+j; each bank
   // serves whichever of the four falls on it. At the first segment the
   // point before wraps to a meaningless slot and is replaced by a mirror.
   // ---------------------------------------------------------------------
   always_comb begin
      logic [1:0]       off;
      logic [IDX_W-1:0] idx;
      base = IDX_W'(s4_seg_ff) - IDX_W'(1);
      for (int b = 0; b < 4; b++) begin
         off        = 2'(b) - base[1:0];
         idx        = base + IDX_W'(off);
         rd_addr[b] = BANK_AW'(idx >> 2);
      end
      load_ok = s4_valid_ff && (s4_mode_ff == crp_pkg::MODE_LOAD)
             && (32'(s4_idx_ff) < MAX_POINTS);
      wr_addr = BANK_AW'(s4_idx_ff >> 2);
      for (int b = 0; b < 4; b++) begin
         bank_we[b] = load_ok && (s4_idx_ff[1:0] == 2'(b));
      end
      nbr_in.has_prev = (s4_seg_ff != '0);
      nbr_in.has_next = (32'(s4_seg_ff) + 32'd2) < 32'(n_eff);
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      crp_ram #(
         .WIDTH (PT_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (wr_addr),
         .wr_data (s4_pt_ff),
         .rd_addr (rd_addr[b]),
         .rd_data (bank_rd[b])
      );
   end

   // Query tracking behind the banks, with the overshoot carried alongside.
   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= '0;
      end else begin
         qv_ff <= {qv_ff[7:0], s4_valid_ff && (s4_mode_ff == crp_pkg::MODE_QUERY)};
      end
   end

   always_ff @(posedge clock) begin
      rot_ff       <= base[1:0];
      nbr_ff       <= nbr_in;
      over_d_ff[0] <= s4_over_ff;
      for (int k = 1; k < 5; k++) begin
         over_d_ff[k] <= over_d_ff[k-1];
      end
      ovnz_ff <= {ovnz_ff[7:0], s4_over_ff != '0};
   end

   // Fraction to basis weights, aligned with the mirrored points.
   crp_basis u_basis (
      .clock (clock),
      .u     (s4_u_ff),
      .basis (basis)
   );

   // Rotate the bank words back into neighbour order for each coordinate.
   always_comb begin
      logic [1:0] sel;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 4; j++) begin
            sel        = rot_ff + 2'(j);
            q_raw[k][j] = $signed(bank_rd[sel][32*k +: 32]);
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      crp_lane u_lane (
         .clock        (clock),
         .q_raw        (q_raw[k]),
         .nbr          (nbr_ff),
         .basis        (basis),
         .over         (over_d_ff[4]),
         .over_nz      (ovnz_ff[8]),
         .inv_interval (inv_interval_ff),
         .pos          (pos[k]),
         .vel          (vel[k])
      );
   end

   // Result word register: one strobe per query.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= qv_ff[8];
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff.pos_x <= pos[0];
      rsp_word_ff.pos_y <= pos[1];
      rsp_word_ff.pos_z <= pos[2];
      rsp_word_ff.vel_x <= vel[0];
      rsp_word_ff.vel_y <= vel[1];
      rsp_word_ff.vel_z <= vel[2];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_rsp_from_query : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_word.mode == crp_pkg::MODE_QUERY), 14))
      else $error("result word without a query word");

   a_query_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.mode == crp_pkg::MODE_QUERY)) |-> ##14 rsp_valid)
      else $error("query word produced no result word");

   a_one_bank_write : assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("load wrote more than one bank");

   a_segment_in_path : assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && (s4_mode_ff == crp_pkg::MODE_QUERY))
      |-> ((32'(s4_seg_ff) + 32'd2) <= 32'(n_eff)) && (s4_u_ff <= crp_pkg::ONE_Q16))
      else $error("segment or fraction outside the path");

endmodule

// File: tb/sv/crp_path_checker.sv
`timescale 1ns / 1ps

module crp_path_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  crp_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  crp_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output int                    pending,
   output int                    failures
);
   import crp_pkg::*;

   localparam longint TABLE_DEPTH = 64;
   localparam longint UNIT        = 65536;
   localparam longint EXT_CLAMP   = 64'sd1 << 40;

   longint            pts [64][3];
   logic [6:0]        npoints;
   longint            t_origin;
   logic [31:0]       inv_step;
   rsp_word_type      expected_q [$];

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // floor(a * b / 2^16) with the magnitude clamped to lim.
   function automatic longint scaled_product(input longint a, input longint b, input longint lim);
      logic [63:0]  am, bm;
      logic [127:0] prod, shifted;
      logic         neg;
      longint       r;
      am      = (a < 0) ? -a : a;
      bm      = (b < 0) ? -b : b;
      neg     = (a < 0) != (b < 0);
      prod    = {64'd0, am} * {64'd0, bm};
      shifted = prod >> 16;
      if (shifted >= 128'(lim)) return neg ? -lim : lim;
      r = longint'(shifted[63:0]);
      if (neg) begin
         if (prod[15:0] != 0) r = r + 1;
         return -r;
      end
      return r;
   endfunction

   function automatic rsp_word_type eval_path(input req_word_type w);
      longint       n, seg, u, over, u2, u3, diff, s, span, psum, dsum, pos, tang;
      longint       wp [4];
      longint       wd [4];
      longint       q [4];
      logic [63:0]  dm, prod;
      longint       pos_o [3];
      longint       vel_o [3];
      rsp_word_type r;
      n = npoints;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      diff = longint'(w.query_time) - t_origin;
      dm   = (diff < 0) ? -diff : diff;
      prod = dm * {32'd0, inv_step};
      s    = longint'(prod >> 16);
      span = (n - 1) * UNIT;
      if (diff < 0 || s == 0) begin
         seg = 0; u = 0; over = -s;
      end else if (s >= span) begin
         seg = n - 2; u = UNIT; over = s - span;
      end else begin
         seg = s >>> 16; u = s & 16'hFFFF; over = 0;
      end
      u2 = (u * u) >>> 16;
      u3 = (u2 * u) >>> 16;
      wp[0] = -u3 + 2 * u2 - u;
      wp[1] = 3 * u3 - 5 * u2 + 2 * UNIT;
      wp[2] = -3 * u3 + 4 * u2 + u;
      wp[3] = u3 - u2;
      wd[0] = -3 * u2 + 4 * u - UNIT;
      wd[1] = 9 * u2 - 10 * u;
      wd[2] = -9 * u2 + 8 * u + UNIT;
      wd[3] = 3 * u2 - 2 * u;
      for (int k = 0; k < 3; k++) begin
         q[1] = pts[seg][k];
         q[2] = pts[seg + 1][k];
         // Missing neighbours at either end are mirrored about the segment end.
         q[0] = (seg > 0) ? pts[seg - 1][k] : 2 * q[1] - q[2];
         q[3] = (seg + 2 < n) ? pts[seg + 2][k] : 2 * q[2] - q[1];
         psum = 0;
         dsum = 0;
         for (int j = 0; j < 4; j++) begin
            psum += wp[j] * q[j];
            dsum += wd[j] * q[j];
         end
         pos  = psum >>> 17;
         tang = dsum >>> 17;
         if (over != 0) pos += scaled_product(tang, over, EXT_CLAMP);
         pos_o[k] = clip32(pos);
         vel_o[k] = clip32(scaled_product(tang, longint'(inv_step), EXT_CLAMP));
      end
      r.pos_x = pos_o[0][31:0];
      r.pos_y = pos_o[1][31:0];
      r.pos_z = pos_o[2][31:0];
      r.vel_x = vel_o[0][31:0];
      r.vel_y = vel_o[1][31:0];
      r.vel_z = vel_o[2][31:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      failures++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   initial begin
      failures = 0;
      pending  = 0;
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         npoints  = 7'd2;
         t_origin = 0;
         inv_step = 32'd65536;
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result word", 32'd0, 32'd0);
            end else begin
               want = expected_q.pop_front();
               check_field("pos_x", rsp_word.pos_x, want.pos_x);
               check_field("pos_y", rsp_word.pos_y, want.pos_y);
               check_field("pos_z", rsp_word.pos_z, want.pos_z);
               check_field("vel_x", rsp_word.vel_x, want.vel_x);
               check_field("vel_y", rsp_word.vel_y, want.vel_y);
               check_field("vel_z", rsp_word.vel_z, want.vel_z);
            end
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_POINT_COUNT:  npoints  = csr_wdata[6:0];
               CSR_START_TIME:   t_origin = longint'(signed'(csr_wdata));
               CSR_INV_INTERVAL: inv_step = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_word.mode == MODE_LOAD) begin
               pts[req_word.point_index][0] = longint'(req_word.coord_x);
               pts[req_word.point_index][1] = longint'(req_word.coord_y);
               pts[req_word.point_index][2] = longint'(req_word.coord_z);
            end else begin
               expected_q.push_back(eval_path(req_word));
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

// File: tb/sv/tb_catmull_rom_path_eval.sv
`timescale 1ns / 1ps

module tb_catmull_rom_path_eval;
   import crp_pkg::*;

   // Loads give no result word, so the tail after the last expected word is allowed a
   // drain longer than the pipeline before anything else happens.
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 200000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_write_en;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;
   int           pending;
   int           failures;
   int           cycles;
   int           queries_sent;
   int           loads_sent;
   int           settings_used;
   logic [6:0]   cur_count;
   logic [31:0]  cur_origin;

   catmull_rom_path_eval uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // The checker sees exactly what the block sees and keeps its own copy of the
   // point table and the registers; the top only makes stimulus.
   crp_path_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pending      (pending),
      .failures     (failures)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The watchdog allows for every word waiting its longest gap plus the whole pipeline,
   // several times over.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("catmull_rom_path_eval regression: fail");
         $finish;
      end
   end

   // Offers one word after a random gap and holds it until the block accepts it.
   // When there is no gap, start simply stays high for the next word.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start    = 1'b1;
      req_word = w;
      do @(posedge clock); while (busy);
      if (w.mode == MODE_QUERY) queries_sent++;
      else loads_sent++;
   endtask

   task automatic load_point(input logic [5:0] slot, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
      req_word_type w;
      w             = '0;
      w.mode        = MODE_LOAD;
      w.point_index = slot;
      w.coord_x     = x;
      w.coord_y     = y;
      w.coord_z     = z;
      w.query_time  = $urandom();
      send_word(w);
   endtask

   task automatic query_at(input logic [31:0] t);
      req_word_type w;
      w             = '0;
      w.mode        = MODE_QUERY;
      w.point_index = $urandom();
      w.coord_x     = $urandom();
      w.coord_y     = $urandom();
      w.coord_z     = $urandom();
      w.query_time  = t;
      send_word(w);
   endtask

   // Control points are mostly of moderate size so that the curve itself is checked,
   // with some full-range values to drive the outputs into saturation.
   function automatic logic [31:0] random_coord();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
   endfunction

   // Times cluster around the start of the path, where the segments lie for most settings.
   function automatic logic [31:0] random_time();
      case ($urandom_range(0, 4))
         0:       return $urandom();
         1:       return cur_origin;
         2:       return cur_origin + 32'($signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh10_0000);
         default: return cur_origin + 32'($urandom_range(0, 32'h3F_FFFF));
      endcase
   endfunction

   // Lets every expected word arrive, then waits DRAIN_CYCLES in case a load is still in flight.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic apply_setting(input logic [6:0] count, input logic [31:0] origin,
                                input logic [31:0] inv);
      drain();
      write_reg(CSR_POINT_COUNT, {25'd0, count});
      write_reg(CSR_START_TIME, origin);
      write_reg(CSR_INV_INTERVAL, inv);
      cur_count  = count;
      cur_origin = origin;
      settings_used++;
   endtask

   // Mostly queries; the odd load reshapes the path under the running queries.
   task automatic random_burst(input int words);
      repeat (words) begin
         if ($urandom_range(0, 4) == 0)
            load_point($urandom_range(0, 63), random_coord(), random_coord(), random_coord());
         else
            query_at(random_time());
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_word      = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_POINT_COUNT;
      csr_wdata     = '0;
      cycles        = 0;
      queries_sent  = 0;
      loads_sent    = 0;
      settings_used = 0;
      cur_count     = 7'd2;
      cur_origin    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every slot is written before the first query, so that no query can read a
      // point that was never loaded.
      for (int i = 0; i < 64; i++)
         load_point(i[5:0], random_coord(), random_coord(), random_coord());

      // Directed words under the reset settings: two points, start at zero, one second apart.
      load_point(6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      load_point(6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      query_at(32'd0);
      query_at(32'h0000_8000);
      query_at(32'h0001_0000);
      query_at(32'h7FFF_FFFF);
      query_at(32'h8000_0000);
      query_at(32'hFFFF_FFFF);
      load_point(6'd0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
      load_point(6'd1, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000);
      load_point(6'd63, 32'h0010_0000, 32'h0000_0001, 32'hFFF0_0000);
      query_at(32'd1);
      query_at(32'hFFFF_0000);
      query_at(32'h0002_0000);
      query_at(32'h0000_FFFF);

      random_burst(100);

      // Extremes of each register, counts outside the legal range, a zero interval,
      // and a few random settings.
      apply_setting(7'd64, 32'd0, 32'h0001_0000);
      query_at(32'h003F_0000);
      query_at(32'h003E_FFFF);
      random_burst(110);
      apply_setting(7'd0, 32'h8000_0000, 32'd1);
      random_burst(90);
      apply_setting(7'd127, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      random_burst(90);
      apply_setting(7'd1, 32'hFFFF_0000, 32'd0);
      random_burst(60);
      apply_setting(7'd5, 32'h0000_4000, 32'h0000_8000);
      random_burst(110);
      apply_setting(7'd65, 32'hFFFD_0000, 32'h0004_0000);
      random_burst(100);
      repeat (3) begin
         apply_setting(7'($urandom_range(2, 64)), $urandom(),
                       32'($urandom_range(1, 32'h0008_0000)));
         random_burst(100);
      end

      drain();
      $display("covered %0d queries and %0d point loads across %0d register settings",
               queries_sent, loads_sent, settings_used + 1);
      $display("including out-of-range counts, a zero interval and saturating outputs");
      if (failures == 0) begin
         $display("catmull_rom_path_eval regression: pass");
      end else begin
         $display("%0d mismatches", failures);
         $display("catmull_rom_path_eval regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/crp_pkg.sv
rtl/crp_ram.sv
rtl/crp_basis.sv
rtl/crp_mulq16.sv
rtl/crp_lane.sv
rtl/catmull_rom_path_eval.sv
tb/sv/crp_path_checker.sv
tb/sv/tb_catmull_rom_path_eval.sv
